### design/hpe_pkg.sv
// hpe_pkg: shared constants, payload structs and state types for the
// histogram percentile engine; no dependencies
`timescale 1ns / 1ps

package hpe_pkg;

  // sizing
  localparam int MAX_BINS    = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int IDX_W       = $clog2(MAX_BINS);
  localparam int CNT_W       = $clog2(MAX_BINS + 1);
  localparam int TOT_W       = COUNT_WIDTH + $clog2(MAX_BINS);
  localparam int HALF_W      = (TOT_W + 1) / 2;

  // fixed field widths
  localparam int ACT_W      = 2;
  localparam int SAMPLE_W   = 16;
  localparam int PCT_W      = 24;
  localparam int BIN_OUT_W  = 4;
  localparam int TOTAL_W    = 32;
  localparam int CFG_W      = 5;
  localparam int PROD_W     = TOT_W + PCT_W;
  localparam int CPROD_W    = COUNT_WIDTH + PCT_W;

  localparam logic [PCT_W-1:0]       PERCENT_FULL = PCT_W'(10000000);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = {COUNT_WIDTH{1'b1}};
  localparam logic [CFG_W-1:0]       BINS_RESET   = CFG_W'(11);

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // item action codes
  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // register index
  localparam logic REG_BINS_IN_USE = 1'b0;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [SAMPLE_W-1:0] sample;
    logic [PCT_W-1:0]    percent;
  } in_item_t;

  typedef struct packed {
    logic [BIN_OUT_W-1:0] min_bin;
    logic [BIN_OUT_W-1:0] max_bin;
    logic [BIN_OUT_W-1:0] quantile_bin;
    logic [TOTAL_W-1:0]   in_range_total;
    logic [TOTAL_W-1:0]   all_total;
    logic                 saturated;
  } out_result_t;

  typedef enum logic [1:0] {
    CMD_ADD_BIN,
    CMD_ADD_OVF,
    CMD_QUERY,
    CMD_CLEAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [IDX_W-1:0] bin;
    logic [CNT_W-1:0] nbins;
    logic [PCT_W-1:0] percent;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SUM,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_SCAN_MUL,
    BK_SCAN_CMP,
    BK_DONE
  } back_state_t;

  // clamp an exact total to the 32-bit output field
  function automatic logic [TOTAL_W-1:0] clamp_total(input logic [TOT_W:0] v);
    logic [TOTAL_W-1:0] res;
    if ((TOT_W + 1) > TOTAL_W && (v >> TOTAL_W) != '0) begin
      res = {TOTAL_W{1'b1}};
    end else begin
      res = TOTAL_W'(v);
    end
    return res;
  endfunction

endpackage

### design/hpe_front.sv
// hpe_front: input handshake and item classification into queue commands
// depends on hpe_pkg
`timescale 1ns / 1ps

module hpe_front
  import hpe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_item,
  input  logic [CFG_W-1:0]   bins_in_use,
  input  fifo_status_t       fifo_st,
  output logic               push,
  output cmd_t               push_cmd
);

  logic [CNT_W-1:0] nbins;
  logic             keep;
  logic             in_range;
  logic             accepted_r;

  // out-of-range register values fold into 1..MAX_BINS
  always_comb begin
    if (bins_in_use == '0) begin
      nbins = CNT_W'(1);
    end else if (32'(bins_in_use) > MAX_BINS) begin
      nbins = CNT_W'(MAX_BINS);
    end else begin
      nbins = CNT_W'(bins_in_use);
    end
  end

  assign in_range = 32'(in_item.sample) < 32'(nbins);

  always_comb begin
    keep             = 1'b1;
    push_cmd.op      = CMD_QUERY;
    push_cmd.bin     = IDX_W'(in_item.sample);
    push_cmd.nbins   = nbins;
    push_cmd.percent = in_item.percent;
    unique case (in_item.action)
      ACT_ADD:   push_cmd.op = in_range ? CMD_ADD_BIN : CMD_ADD_OVF;
      ACT_QUERY: push_cmd.op = CMD_QUERY;
      ACT_CLEAR: push_cmd.op = CMD_CLEAR;
      default:   keep = 1'b0;
    endcase
  end

  assign in_stall = fifo_st.full;
  assign push     = in_valid && !fifo_st.full && keep;

  // tracks last accept for the check below
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accepted_r <= 1'b0;
    end else begin
      accepted_r <= in_valid && !in_stall;
    end
  end

  a_push_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (in_valid && !fifo_st.full))
    else $error("queue push without an accepted item");

  a_no_push_after_full: assert property (@(posedge clk) disable iff (!rst_n)
    (accepted_r && $past(fifo_st.full)) |-> 1'b0)
    else $error("item accepted while queue full");

endmodule

### design/hpe_fifo.sv
// hpe_fifo: short command queue between the front and back parts
// depends on hpe_pkg
`timescale 1ns / 1ps

module hpe_fifo
  import hpe_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  cmd_t         push_cmd,
  input  logic         pop,
  output cmd_t         head_cmd,
  output fifo_status_t st
);

  cmd_t              entry_r [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FCNT_W-1:0] count_r, count_nxt;

  assign st.empty = (count_r == '0);
  assign st.full  = (count_r == FCNT_W'(FIFO_DEPTH));
  assign head_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? FPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? FPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    st.full |-> !push)
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    st.empty |-> !pop)
    else $error("pop from empty queue");

endmodule

### design/hpe_back.sv
// hpe_back: bin count storage, add/clear execution, query sequencer and
// result register; depends on hpe_pkg
`timescale 1ns / 1ps

module hpe_back
  import hpe_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  cmd_t         head_cmd,
  input  fifo_status_t fifo_st,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_stall,
  output out_result_t  out_result
);

  back_state_t state_r, state_nxt;

  logic [COUNT_WIDTH-1:0] bins_r [MAX_BINS];
  logic [COUNT_WIDTH-1:0] bins_nxt [MAX_BINS];
  logic [COUNT_WIDTH-1:0] ovf_r, ovf_nxt;
  logic                   sat_r, sat_nxt;

  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   nb_r, nb_nxt;
  logic [PCT_W-1:0]   pct_r, pct_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic [IDX_W-1:0]   lo_r, lo_nxt;
  logic [IDX_W-1:0]   hi_r, hi_nxt;
  logic               found_lo_r, found_lo_nxt;
  logic [IDX_W-1:0]   q_r, q_nxt;
  logic [PROD_W-1:0]  tgt_r, tgt_nxt;
  logic [PROD_W-1:0]  run_r, run_nxt;
  logic [CPROD_W-1:0] prod_r, prod_nxt;

  logic        out_valid_r, out_valid_nxt;
  out_result_t out_result_r, out_result_nxt;

  logic [IDX_W-1:0]                rd_addr;
  logic [COUNT_WIDTH-1:0]          cur;
  logic                            last;
  logic                            slot_free;
  logic [PROD_W-1:0]               run_sum;
  logic                            hit;
  logic [PCT_W+HALF_W-1:0]         mlo;
  logic [PCT_W+TOT_W-HALF_W-1:0]   mhi;
  logic [CPROD_W-1:0]              cprod;

  // single read port: the queue head's bin when idle, the walk index otherwise
  assign rd_addr   = (state_r == BK_IDLE) ? head_cmd.bin : idx_r[IDX_W-1:0];
  assign cur       = bins_r[rd_addr];
  assign last      = (idx_r == nb_r - CNT_W'(1));
  assign slot_free = !out_valid_r || !out_stall;
  assign run_sum   = run_r + PROD_W'(prod_r);
  assign hit       = (run_sum >= tgt_r);

  // target percent * total, built from two narrower products
  assign mlo = {{HALF_W{1'b0}}, pct_r} * {{PCT_W{1'b0}}, total_r[HALF_W-1:0]};
  assign mhi = {{(TOT_W-HALF_W){1'b0}}, pct_r} *
               {{PCT_W{1'b0}}, total_r[TOT_W-1:HALF_W]};
  assign cprod = {{PCT_W{1'b0}}, cur} * {{COUNT_WIDTH{1'b0}}, PERCENT_FULL};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:     if (!fifo_st.empty && head_cmd.op == CMD_QUERY) state_nxt = BK_SUM;
      BK_SUM:      if (last) state_nxt = BK_MUL_LO;
      BK_MUL_LO:   state_nxt = BK_MUL_HI;
      BK_MUL_HI:   state_nxt = BK_SCAN_MUL;
      BK_SCAN_MUL: state_nxt = BK_SCAN_CMP;
      BK_SCAN_CMP: state_nxt = (hit || last) ? BK_DONE : BK_SCAN_MUL;
      BK_DONE:     if (slot_free) state_nxt = BK_IDLE;
      default:     state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop            = 1'b0;
    bins_nxt       = bins_r;
    ovf_nxt        = ovf_r;
    sat_nxt        = sat_r;
    idx_nxt        = idx_r;
    nb_nxt         = nb_r;
    pct_nxt        = pct_r;
    total_nxt      = total_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    found_lo_nxt   = found_lo_r;
    q_nxt          = q_r;
    tgt_nxt        = tgt_r;
    run_nxt        = run_r;
    prod_nxt       = prod_r;
    out_result_nxt = out_result_r;
    out_valid_nxt  = out_valid_r && out_stall;
    unique case (state_r)
      BK_IDLE: begin
        if (!fifo_st.empty) begin
          pop = 1'b1;
          unique case (head_cmd.op)
            CMD_ADD_BIN: begin
              if (cur == COUNT_MAX) begin
                sat_nxt = 1'b1;
              end else begin
                bins_nxt[head_cmd.bin] = cur + 1'b1;
              end
            end
            CMD_ADD_OVF: begin
              if (ovf_r == COUNT_MAX) begin
                sat_nxt = 1'b1;
              end else begin
                ovf_nxt = ovf_r + 1'b1;
              end
            end
            CMD_CLEAR: begin
              for (int i = 0; i < MAX_BINS; i++) begin
                bins_nxt[i] = '0;
              end
              ovf_nxt = '0;
              sat_nxt = 1'b0;
            end
            CMD_QUERY: begin
              nb_nxt       = head_cmd.nbins;
              pct_nxt      = head_cmd.percent;
              idx_nxt      = '0;
              total_nxt    = '0;
              lo_nxt       = '0;
              hi_nxt       = '0;
              found_lo_nxt = 1'b0;
              q_nxt        = '0;
              run_nxt      = '0;
            end
            default: ;
          endcase
        end
      end
      BK_SUM: begin
        total_nxt = total_r + TOT_W'(cur);
        if (cur != '0) begin
          if (!found_lo_r) begin
            lo_nxt       = idx_r[IDX_W-1:0];
            found_lo_nxt = 1'b1;
          end
          hi_nxt = idx_r[IDX_W-1:0];
        end
        idx_nxt = last ? '0 : idx_r + 1'b1;
      end
      BK_MUL_LO:   tgt_nxt = PROD_W'(mlo);
      BK_MUL_HI:   tgt_nxt = tgt_r + (PROD_W'(mhi) << HALF_W);
      BK_SCAN_MUL: prod_nxt = cprod;
      BK_SCAN_CMP: begin
        run_nxt = run_sum;
        if (hit) begin
          q_nxt = idx_r[IDX_W-1:0];
        end else if (!last) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      BK_DONE: begin
        if (slot_free) begin
          out_valid_nxt                 = 1'b1;
          out_result_nxt.min_bin        = BIN_OUT_W'(lo_r);
          out_result_nxt.max_bin        = BIN_OUT_W'(hi_r);
          out_result_nxt.quantile_bin   = BIN_OUT_W'(q_r);
          out_result_nxt.in_range_total = clamp_total({1'b0, total_r});
          out_result_nxt.all_total      =
            clamp_total({1'b0, total_r} + (TOT_W + 1)'(ovf_r));
          out_result_nxt.saturated      = sat_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      ovf_r       <= '0;
      sat_r       <= 1'b0;
      for (int i = 0; i < MAX_BINS; i++) begin
        bins_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ovf_r       <= ovf_nxt;
      sat_r       <= sat_nxt;
      bins_r      <= bins_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    nb_r         <= nb_nxt;
    pct_r        <= pct_nxt;
    total_r      <= total_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    found_lo_r   <= found_lo_nxt;
    q_r          <= q_nxt;
    tgt_r        <= tgt_nxt;
    run_r        <= run_nxt;
    prod_r       <= prod_nxt;
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SUM || state_r == BK_SCAN_MUL || state_r == BK_SCAN_CMP)
      |-> (idx_r < nb_r))
    else $error("bin walk index beyond active bins");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DONE && slot_free) |=> (out_valid_r && state_r == BK_IDLE))
    else $error("finished query not placed in result register");

endmodule

### design/histogram_percentile_engine_core.sv
// histogram_percentile_engine_core: top level with the configuration port,
// front classifier, command queue and back execution unit; depends on hpe_pkg
`timescale 1ns / 1ps

// Histogram of up to 16 unit-width bins starting at 0, with an overflow
// counter for samples at or above bins_in_use (register 0, byte address 0,
// reset 11; 0 acts as 1, values above 16 act as 16). Items on the input
// channel are add (0), query (1) or clear (2); action 3 is taken and dropped.
// Only a query returns an item on the result channel: lowest and highest
// nonzero bin, the first bin whose running sum reaches percent/10^7 of the
// in-range total (exact integer compare), both totals clamped to 32 bits and
// the sticky saturation flag. Counters saturate at all ones. The front side
// classifies each item combinationally and drops it into a four-entry command
// queue, so it keeps taking items while the back is busy or a result waits
// until the queue is full. The back executes each add or clear as it pops
// it; a query walks the active bins through one shared read port: it sums
// them, builds the target product from a low and a high half, multiplies
// and compares bin by bin until the quantile bin is found, and loads the
// result register. No clearing pass after reset: counts reset at once.

module histogram_percentile_engine_core
  import hpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output out_result_t out_result,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CFG_W-1:0] bins_in_use_r, bins_in_use_nxt;
  logic             reg_sel;

  fifo_status_t fifo_st;
  logic         push;
  cmd_t         push_cmd;
  logic         pop;
  cmd_t         head_cmd;

  // register decode: word index sits above the byte offset
  assign reg_sel = (paddr[2] == REG_BINS_IN_USE);
  assign pready  = 1'b1;

  always_comb begin
    bins_in_use_nxt = bins_in_use_r;
    if (psel && penable && pwrite && reg_sel) begin
      bins_in_use_nxt = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_in_use_r <= BINS_RESET;
    end else begin
      bins_in_use_r <= bins_in_use_nxt;
    end
  end

  // reads of unused addresses return zero
  assign prdata = reg_sel ? {{(32-CFG_W){1'b0}}, bins_in_use_r} : '0;

  // front: handshake and classification
  hpe_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .bins_in_use (bins_in_use_r),
    .fifo_st     (fifo_st),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // decoupling queue
  hpe_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .st       (fifo_st)
  );

  // back: counters, query walk, result register
  hpe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_cmd   (head_cmd),
    .fifo_st    (fifo_st),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

endmodule

### bench/tb.sv
// tb: self-checking bench for histogram_percentile_engine_core, directed table then
// random add/query/clear traffic checked against an in-bench histogram model
// depends on hpe_pkg and the core rtl only
`timescale 1ns / 1ps

module tb;
  import hpe_pkg::*;

  localparam int N_DIR         = 22;
  localparam int N_PHASES      = 6;
  localparam int PHASE_ITEMS   = 275;
  localparam int IDLE_PCT      = 23;
  // drain margin: four queued commands plus a full 16-bin query walk, with slack
  localparam int SETTLE_CYCLES = 120;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [2:0] BINS_ADDR = 3'(4 * int'(REG_BINS_IN_USE));
  localparam longint unsigned CNT_LIMIT = 64'(COUNT_MAX);
  localparam longint unsigned OUT_LIMIT = 64'hFFFF_FFFF;

  // one row of the directed table; stats only used when known is set
  typedef struct packed {
    in_item_t    item;
    logic        known;
    out_result_t stats;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_result_t out_result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the block state, updated as items are accepted
  longint unsigned hist_count [MAX_BINS];
  longint unsigned ovf_count;
  bit              sat_seen;
  logic [CFG_W-1:0] bins_reg;

  out_result_t pending_stats [$];
  int          errors = 0;
  bit          calm   = 1'b0;

  histogram_percentile_engine_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  // build one directed row; the typed-in result applies only to queries marked known
  function automatic stim_row_t row(input logic [ACT_W-1:0] act,
                                    input logic [SAMPLE_W-1:0] smp,
                                    input logic [PCT_W-1:0] pct,
                                    input bit known = 1'b0,
                                    input logic [3:0] mn = 4'd0,
                                    input logic [3:0] mx = 4'd0,
                                    input logic [3:0] q = 4'd0,
                                    input logic [31:0] inr = 32'd0,
                                    input logic [31:0] all = 32'd0);
    stim_row_t r;
    r.item.action        = act;
    r.item.sample        = smp;
    r.item.percent       = pct;
    r.known              = known;
    r.stats.min_bin        = mn;
    r.stats.max_bin        = mx;
    r.stats.quantile_bin   = q;
    r.stats.in_range_total = inr;
    r.stats.all_total      = all;
    r.stats.saturated      = 1'b0;
    return r;
  endfunction

  // directed part, run with the reset setting of 11 bins
  stim_row_t dir_rows [N_DIR] = '{
    // empty histogram: everything reads zero
    row(ACT_QUERY, 16'd0,     24'd5000000, 1'b1, 4'd0, 4'd0, 4'd0, 32'd0, 32'd0),
    row(ACT_ADD,   16'd0,     24'd0),
    // last bin in use, then the first overflow sample and the largest sample
    row(ACT_ADD,   16'd10,    24'd0),
    row(ACT_ADD,   16'd11,    24'd0),
    row(ACT_ADD,   16'hFFFF,  24'hFFFFFF),
    // zero percent is met by the first bin
    row(ACT_QUERY, 16'd0,     24'd0,       1'b1, 4'd0, 4'd10, 4'd0, 32'd2, 32'd4),
    // full hundred percent lands on the highest nonzero bin
    row(ACT_QUERY, 16'd0,     24'd10000000, 1'b1, 4'd0, 4'd10, 4'd10, 32'd2, 32'd4),
    // above a hundred percent nothing qualifies, quantile reads zero
    row(ACT_QUERY, 16'hFFFF,  24'hFFFFFF,  1'b1, 4'd0, 4'd10, 4'd0, 32'd2, 32'd4),
    // unused action code is swallowed with no effect
    row(ACT_UNUSED, 16'hFFFF, 24'hFFFFFF),
    row(ACT_QUERY, 16'd0,     24'd5000000),
    row(ACT_ADD,   16'd5,     24'd0),
    row(ACT_ADD,   16'd5,     24'hFFFFFF),
    row(ACT_ADD,   16'd5,     24'd0),
    row(ACT_QUERY, 16'd0,     24'd5000000),
    row(ACT_QUERY, 16'd0,     24'd5000001),
    row(ACT_CLEAR, 16'hFFFF,  24'hFFFFFF),
    // after clear the overflow total is gone too
    row(ACT_QUERY, 16'hFFFF,  24'd10000000, 1'b1, 4'd0, 4'd0, 4'd0, 32'd0, 32'd0),
    row(ACT_ADD,   16'd7,     24'd0),
    row(ACT_ADD,   16'd3,     24'd0),
    row(ACT_QUERY, 16'd0,     24'd8000000),
    row(ACT_ADD,   16'd10,    24'd0),
    row(ACT_QUERY, 16'd0,     24'd1)
  };

  // register settings for the random phases: full width, one bin, zero acting as one,
  // all ones and just above the maximum acting as the maximum, then a mid value
  logic [CFG_W-1:0] bins_plan [N_PHASES] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd7};

  function automatic int active_bins();
    if (bins_reg == '0) return 1;
    if (int'(bins_reg) > MAX_BINS) return MAX_BINS;
    return int'(bins_reg);
  endfunction

  // min/max nonzero bin, first bin meeting run*10^7 >= percent*total, clamped totals
  function automatic out_result_t histogram_stats(input logic [PCT_W-1:0] pct);
    out_result_t     r;
    int              n;
    longint unsigned total;
    longint unsigned run;
    bit              lo_found;
    bit              q_found;
    r        = '0;
    n        = active_bins();
    total    = 0;
    run      = 0;
    lo_found = 1'b0;
    q_found  = 1'b0;
    for (int i = 0; i < n; i++) begin
      total += hist_count[i];
      if (hist_count[i] != 0) begin
        if (!lo_found) r.min_bin = BIN_OUT_W'(i);
        lo_found  = 1'b1;
        r.max_bin = BIN_OUT_W'(i);
      end
    end
    for (int i = 0; i < n && !q_found; i++) begin
      run += hist_count[i];
      if (run * 64'(PERCENT_FULL) >= 64'(pct) * total) begin
        r.quantile_bin = BIN_OUT_W'(i);
        q_found        = 1'b1;
      end
    end
    r.in_range_total = (total > OUT_LIMIT) ? '1 : TOTAL_W'(total);
    r.all_total      = (total + ovf_count > OUT_LIMIT) ? '1 : TOTAL_W'(total + ovf_count);
    r.saturated      = sat_seen;
    return r;
  endfunction

  // percent that sits exactly on (or one past) the running sum of a random bin
  function automatic logic [PCT_W-1:0] boundary_percent();
    int              n;
    int              k;
    longint unsigned total;
    longint unsigned prefix;
    n      = active_bins();
    k      = $urandom_range(0, n - 1);
    total  = 0;
    prefix = 0;
    for (int i = 0; i < n; i++) begin
      total += hist_count[i];
      if (i <= k) prefix += hist_count[i];
    end
    if (total == 0) return PCT_W'($urandom_range(0, 10000000));
    return PCT_W'(prefix * 64'(PERCENT_FULL) / total + 64'($urandom_range(0, 1)));
  endfunction

  // apply one accepted item to the shadow state, queue the stats a query owes
  task automatic record_item(input in_item_t it, input bit known, input out_result_t given);
    longint unsigned c;
    bit              in_range;
    case (it.action)
      ACT_ADD: begin
        in_range = int'(it.sample) < active_bins();
        c = in_range ? hist_count[it.sample] : ovf_count;
        if (c >= CNT_LIMIT) begin
          c        = CNT_LIMIT;
          sat_seen = 1'b1;
        end else begin
          c++;
        end
        if (in_range) hist_count[it.sample] = c;
        else ovf_count = c;
      end
      ACT_QUERY: begin
        pending_stats.push_back(known ? given : histogram_stats(it.percent));
      end
      ACT_CLEAR: begin
        foreach (hist_count[i]) hist_count[i] = 0;
        ovf_count = 0;
        sat_seen  = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic report_fail(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) report_fail($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  // entered and left just after a falling edge; random gaps before valid rises
  task automatic send_item(input in_item_t it, input bit known, input out_result_t given);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    record_item(it, known, given);
    @(negedge clk);
  endtask

  // block idle: every query answered, then time for trailing adds and clears
  task automatic settle();
    in_valid = 1'b0;
    while (pending_stats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write bins_in_use with random upper bits, then read it back
  task automatic write_bins(input logic [CFG_W-1:0] v);
    logic [31:0] word;
    word             = $urandom;
    word[CFG_W-1:0]  = v;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = BINS_ADDR;
    pwdata  = word;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    bins_reg = v;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("bins_in_use readback", 32'(v), 32'(prdata[CFG_W-1:0]));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // random item; adds mostly land in or just past the active bins so the
  // histogram fills up, queries often aim right at a running-sum boundary
  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    it.sample  = SAMPLE_W'($urandom);
    it.percent = PCT_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 70) begin
      it.action = ACT_ADD;
      r = $urandom_range(0, 99);
      if (r < 75) it.sample = SAMPLE_W'($urandom_range(0, active_bins() + 1));
      else if (r < 85) it.sample = SAMPLE_W'($urandom_range(0, 40));
    end else if (r < 90) begin
      it.action = ACT_QUERY;
      r = $urandom_range(0, 99);
      if (r < 35) it.percent = boundary_percent();
      else if (r < 60) it.percent = PCT_W'($urandom_range(0, 10000000));
      else if (r < 70) it.percent = ($urandom_range(0, 1) != 0) ? PERCENT_FULL : '0;
      else if (r < 75) it.percent = PCT_W'(10000000 + $urandom_range(1, 6777215));
    end else if (r < 92) begin
      it.action = ACT_CLEAR;
    end else begin
      it.action = ACT_UNUSED;
    end
    return it;
  endfunction

  // result side: random stall, none while the calm phase runs
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // result checker: each taken item is compared with the oldest queued expectation
  always @(posedge clk) begin : result_check
    out_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_stats.size() == 0) begin
        report_fail($sformatf("unexpected result %h", out_result));
      end else begin
        want = pending_stats.pop_front();
        check_field("min_bin",        32'(want.min_bin),      32'(out_result.min_bin));
        check_field("max_bin",        32'(want.max_bin),      32'(out_result.max_bin));
        check_field("quantile_bin",   32'(want.quantile_bin), 32'(out_result.quantile_bin));
        check_field("in_range_total", want.in_range_total,    out_result.in_range_total);
        check_field("all_total",      want.all_total,         out_result.all_total);
        check_field("saturated",      32'(want.saturated),    32'(out_result.saturated));
      end
    end
  end

  // hard stop well past the slowest legal run
  initial begin
    #10ms;
    $display("tb: FAIL");
    $finish;
  end

  // main sequence: reset, directed table, then one random phase per register setting
  initial begin : stimulus
    in_item_t it;
    int       done;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    foreach (hist_count[i]) hist_count[i] = 0;
    ovf_count = 0;
    sat_seen  = 1'b0;
    bins_reg  = BINS_RESET;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].stats);

    // counts are kept across setting changes, so bins hidden by a smaller
    // setting come back when it grows again
    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      write_bins(bins_plan[p]);
      calm = (p == 3);
      done = 0;
      while (done < PHASE_ITEMS) begin
        it = random_item();
        send_item(it, 1'b0, '0);
        done++;
      end
    end
    calm = 1'b0;
    settle();

    if (errors == 0 && pending_stats.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
design/hpe_pkg.sv
design/hpe_front.sv
design/hpe_fifo.sv
design/hpe_back.sv
design/histogram_percentile_engine_core.sv
bench/tb.sv
